FILE: rtl/core/rcts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcts_pkg
// Shared types and codes for the reference-counted tag slot table:
// command and status codes, entry layout, default table size.
// ----------------------------------------------------------------------------
package rcts_pkg;

   // default table depth
   localparam int NUM_SLOTS_DEFAULT = 16;

   // field widths
   localparam int CMD_W    = 3;
   localparam int KIND_W   = 3;
   localparam int TAG_W    = 16;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_ADDED    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd4;

   // configuration register map
   localparam int                  CSR_ADDR_W      = 3;
   localparam logic                CSR_IDX_FALLBACK = 1'b0;

   // kind code for a free slot
   localparam logic [KIND_W-1:0] KIND_FREE = 3'd0;

   // one stored slot
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage
`default_nettype wire

FILE: rtl/core/rcts_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcts_req_if
// Command channel of the slot table: valid/ready handshake plus command,
// entry kind, tag and slot index.
// ----------------------------------------------------------------------------
interface rcts_req_if import rcts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [KIND_W-1:0] entry_kind;
   logic [TAG_W-1:0]  tag;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output cmd, output entry_kind, output tag,
                   output slot, input ready);
   modport sink   (input valid, input cmd, input entry_kind, input tag,
                   input slot, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rcts_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcts_rsp_if
// Result channel of the slot table: valid/ready handshake plus status and
// the contents of the slot the command touched.
// ----------------------------------------------------------------------------
interface rcts_rsp_if import rcts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   result_slot;
   logic [KIND_W-1:0]   slot_kind;
   logic [COUNT_W-1:0]  slot_count;
   logic [TAG_W-1:0]    slot_tag;

   modport source (output valid, output status, output result_slot,
                   output slot_kind, output slot_count, output slot_tag,
                   input ready);
   modport sink   (input valid, input status, input result_slot,
                   input slot_kind, input slot_count, input slot_tag,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/core/refcounted_tag_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_tag_slot_table
// Table of NUM_SLOTS slots (kind, tag, reference count) with lookup, acquire,
// add, release, remove, clear and read commands.
//
// Usage:
//   req_chan carries one command transaction; rsp_chan returns exactly one
//   result transaction for it. req_chan.ready is high only while the block
//   is idle; one command is in flight at a time.
//   Every scanning command makes one pass over the slot memory through a single
//   compare unit, one slot per cycle (one write port, registered read).
//   Release and read touch only the named slot.
//   A command passes through the scan, decide and respond states, and
//   rsp_chan.valid is raised in the respond state.
//   The next command is taken the cycle after the result transaction.
//   If the receiver stalls, the result is held in the output register and
//   no new command is accepted until it is taken.
//   Reset clears the per-slot occupied bits, so every slot reads as free at
//   once; no clearing pass is needed. fallback_ff resets to 1.
//   The APB port may be written only while no command is in flight.
// ----------------------------------------------------------------------------
module refcounted_tag_slot_table import rcts_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rcts_req_if.sink                   req_chan,
   rcts_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   localparam int              IDX_W    = $clog2(NUM_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // command fields
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // scan sequencer
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             issue_done_ff, issue_done_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   // slot memory and occupied bits
   entry_type             slot_mem_ff [NUM_SLOTS];
   entry_type             rd_data_ff;
   logic                  rd_occ_ff, rd_occ_in;
   logic [NUM_SLOTS-1:0]  valid_ff, valid_in;

   // scan results
   logic             match_hit_ff, match_hit_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   entry_type        match_ent_ff, match_ent_in;
   logic             free_hit_ff, free_hit_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   entry_type        sel_ent_ff, sel_ent_in;
   logic             sel_occ_ff, sel_occ_in;

   // memory write port
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   entry_type           rsp_ent_ff, rsp_ent_in;

   // configuration
   logic fallback_ff, fallback_in;

   logic             req_take;
   logic             rsp_take;
   logic             single_read;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W-1:0] sel_idx;
   logic             slot_ok;
   logic             set_occ;
   logic             clr_occ;
   logic             clr_all;
   entry_type        cur_ent;
   logic [COUNT_W-1:0] rel_count;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      sat_inc = (c == COUNT_MAX) ? c : c + 8'd1;
   endfunction

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.result_slot = rsp_slot_ff;
   assign rsp_chan.slot_kind   = rsp_ent_ff.kind;
   assign rsp_chan.slot_count  = rsp_ent_ff.count;
   assign rsp_chan.slot_tag    = rsp_ent_ff.tag;

   // APB register
   assign pready      = 1'b1;
   assign prdata      = (paddr[2] == CSR_IDX_FALLBACK) ? {31'd0, fallback_ff} : 32'd0;
   assign fallback_in = (psel && penable && pwrite && pready &&
                         paddr[2] == CSR_IDX_FALLBACK) ? pwdata[0] : fallback_ff;

   // slot-addressed commands touch one entry only
   assign single_read = (cmd_ff == CMD_RELEASE) || (cmd_ff == CMD_READ);
   assign slot_idx    = IDX_W'(slot_ff);
   assign sel_idx     = single_read ? slot_idx : '0;
   assign slot_ok     = ({28'd0, slot_ff} < 32'(NUM_SLOTS));

   // occupied bit at the scan pointer, registered beside the memory read
   assign rd_occ_in  = valid_ff[scan_ff];
   assign cur_ent    = rd_occ_ff ? rd_data_ff : '0;
   assign rel_count  = (sel_occ_ff && sel_ent_ff.count != 8'd0) ?
                       sel_ent_ff.count - 8'd1 : 8'd0;

   // sequencer, compare unit and decision
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      kind_in       = kind_ff;
      tag_in        = tag_ff;
      slot_in       = slot_ff;
      scan_in       = scan_ff;
      issue_done_in = issue_done_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = scan_ff;
      match_hit_in  = match_hit_ff;
      match_idx_in  = match_idx_ff;
      match_ent_in  = match_ent_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      sel_ent_in    = sel_ent_ff;
      sel_occ_in    = sel_occ_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ent_in    = rsp_ent_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      set_occ       = 1'b0;
      clr_occ       = 1'b0;
      clr_all       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in        = req_chan.cmd;
               kind_in       = req_chan.entry_kind;
               tag_in        = req_chan.tag;
               slot_in       = req_chan.slot;
               issue_done_in = 1'b0;
               match_hit_in  = 1'b0;
               free_hit_in   = 1'b0;
               sel_occ_in    = 1'b0;
               sel_ent_in    = '0;
               if (req_chan.cmd == CMD_RELEASE || req_chan.cmd == CMD_READ) begin
                  scan_in = IDX_W'(req_chan.slot);
               end else begin
                  scan_in = '0;
               end
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue side
            if (!issue_done_ff) begin
               cmp_vld_in = 1'b1;
               if (single_read || scan_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_in = scan_ff + IDX_W'(1);
               end
            end
            // compare side
            if (cmp_vld_ff) begin
               if (cmp_idx_ff == sel_idx) begin
                  sel_ent_in = rd_data_ff;
                  sel_occ_in = rd_occ_ff;
               end
               if (cmd_ff == CMD_REMOVE) begin
                  if (rd_occ_ff && rd_data_ff.tag == tag_ff) begin
                     valid_in[cmp_idx_ff] = 1'b0;
                     if (!match_hit_ff) begin
                        match_hit_in = 1'b1;
                        match_idx_in = cmp_idx_ff;
                     end
                  end
               end else begin
                  if (!match_hit_ff && rd_occ_ff && rd_data_ff.kind == kind_ff &&
                      rd_data_ff.tag == tag_ff) begin
                     match_hit_in = 1'b1;
                     match_idx_in = cmp_idx_ff;
                     match_ent_in = cur_ent;
                  end
                  if (!free_hit_ff && !rd_occ_ff) begin
                     free_hit_in = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
               end
            end
            if (issue_done_ff && !cmp_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            rsp_status_in = STAT_NOTFOUND;
            rsp_slot_in   = '0;
            rsp_ent_in    = '0;
            case (cmd_ff)
               CMD_LOOKUP, CMD_ACQUIRE, CMD_ADD: begin
                  if (kind_ff == KIND_FREE) begin
                     rsp_status_in = STAT_NOTFOUND;
                  end else if (cmd_ff != CMD_ADD && match_hit_ff) begin
                     wr_addr = match_idx_ff;
                     wr_data = match_ent_ff;
                     if (cmd_ff == CMD_ACQUIRE) begin
                        wr_en         = 1'b1;
                        wr_data.count = sat_inc(match_ent_ff.count);
                     end
                     rsp_status_in = STAT_FOUND;
                     rsp_slot_in   = SLOT_W'(match_idx_ff);
                     rsp_ent_in    = wr_data;
                  end else if (cmd_ff == CMD_LOOKUP) begin
                     rsp_status_in = STAT_NOTFOUND;
                  end else if (free_hit_ff) begin
                     // claim lowest free slot; a free slot always counts zero
                     wr_en         = 1'b1;
                     set_occ       = 1'b1;
                     wr_addr       = free_idx_ff;
                     wr_data.kind  = kind_ff;
                     wr_data.tag   = tag_ff;
                     wr_data.count = (cmd_ff == CMD_ACQUIRE) ? 8'd1 : 8'd0;
                     rsp_status_in = STAT_ADDED;
                     rsp_slot_in   = SLOT_W'(free_idx_ff);
                     rsp_ent_in    = wr_data;
                  end else if (cmd_ff == CMD_ACQUIRE && fallback_ff) begin
                     // table full: count slot zero instead
                     wr_en         = 1'b1;
                     wr_addr       = '0;
                     wr_data       = sel_ent_ff;
                     wr_data.count = sat_inc(sel_ent_ff.count);
                     rsp_status_in = STAT_FULL;
                     rsp_slot_in   = '0;
                     rsp_ent_in    = wr_data;
                  end else begin
                     rsp_status_in = STAT_FULL;
                  end
               end

               CMD_RELEASE: begin
                  if (slot_ok) begin
                     rsp_status_in = STAT_DONE;
                     rsp_slot_in   = slot_ff;
                     wr_addr       = slot_idx;
                     if (rel_count == 8'd0) begin
                        clr_occ = 1'b1;
                     end else begin
                        wr_en         = 1'b1;
                        wr_data       = sel_ent_ff;
                        wr_data.count = rel_count;
                        rsp_ent_in    = wr_data;
                     end
                  end
               end

               CMD_REMOVE: begin
                  if (match_hit_ff) begin
                     rsp_status_in = STAT_DONE;
                     rsp_slot_in   = SLOT_W'(match_idx_ff);
                  end
               end

               CMD_CLEAR: begin
                  clr_all       = 1'b1;
                  rsp_status_in = STAT_DONE;
               end

               CMD_READ: begin
                  if (slot_ok) begin
                     rsp_status_in = STAT_DONE;
                     rsp_slot_in   = slot_ff;
                     rsp_ent_in    = sel_occ_ff ? sel_ent_ff : '0;
                  end
               end

               default: begin
                  rsp_status_in = STAT_NOTFOUND;
               end
            endcase

            if (clr_all) begin
               valid_in = '0;
            end else if (set_occ) begin
               valid_in[wr_addr] = 1'b1;
            end else if (clr_occ) begin
               valid_in[wr_addr] = 1'b0;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         fallback_ff   <= 1'b1;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fallback_ff   <= fallback_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      kind_ff       <= kind_in;
      tag_ff        <= tag_in;
      slot_ff       <= slot_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      rd_occ_ff     <= rd_occ_in;
      match_hit_ff  <= match_hit_in;
      match_idx_ff  <= match_idx_in;
      match_ent_ff  <= match_ent_in;
      free_hit_ff   <= free_hit_in;
      free_idx_ff   <= free_idx_in;
      sel_ent_ff    <= sel_ent_in;
      sel_occ_ff    <= sel_occ_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_ent_ff    <= rsp_ent_in;
   end

   // slot memory: write port and registered read at the scan pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[scan_ff];
   end

endmodule
`default_nettype wire

FILE: tb/sv/slot_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_checker
// Watches the command, result and APB ports of the slot table. It keeps its
// own copy of the table and of the fallback register, predicts the result of
// every accepted command and compares each result transaction against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module slot_table_checker import rcts_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rcts_req_if                        req_mon,
   rcts_rsp_if                        rsp_mon,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output int                         n_errors,
   output int                         n_waiting
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [KIND_W-1:0]   kind;
      logic [COUNT_W-1:0]  count;
      logic [TAG_W-1:0]    tag;
   } slot_result_type;

   // shadow copy of the slot table and the fallback register
   logic [KIND_W-1:0]  kind_tbl [NUM_SLOTS];
   logic [TAG_W-1:0]   tag_tbl  [NUM_SLOTS];
   logic [COUNT_W-1:0] cnt_tbl  [NUM_SLOTS];
   logic               fallback_on;

   slot_result_type pending_results [$];

   // result that shows the contents of slot s
   function automatic slot_result_type slot_view(logic [STATUS_W-1:0] st, int s);
      slot_result_type r;
      r.status = st;
      r.slot   = SLOT_W'(s);
      r.kind   = kind_tbl[s];
      r.count  = cnt_tbl[s];
      r.tag    = tag_tbl[s];
      return r;
   endfunction

   // result with the slot contents zeroed
   function automatic slot_result_type no_slot(logic [STATUS_W-1:0] st, int s);
      slot_result_type r;
      r        = '0;
      r.status = st;
      r.slot   = SLOT_W'(s);
      return r;
   endfunction

   function automatic void bump_count(int s);
      if (cnt_tbl[s] != COUNT_MAX) cnt_tbl[s] = cnt_tbl[s] + COUNT_W'(1);
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         kind_tbl[i] = KIND_FREE;
         tag_tbl[i]  = '0;
         cnt_tbl[i]  = '0;
      end
   endfunction

   // lowest slot holding kind and tag, or -1
   function automatic int find_entry(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (kind_tbl[i] == kind && tag_tbl[i] == tag) return i;
      return -1;
   endfunction

   // claim the lowest free slot, or -1 when the table is full
   function automatic int claim_entry(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (kind_tbl[i] == KIND_FREE) begin
            kind_tbl[i] = kind;
            tag_tbl[i]  = tag;
            return i;
         end
      end
      return -1;
   endfunction

   // apply one command to the shadow table and return its result
   function automatic slot_result_type table_apply(logic [CMD_W-1:0] cmd,
                                                   logic [KIND_W-1:0] kind,
                                                   logic [TAG_W-1:0] tag,
                                                   logic [SLOT_W-1:0] slot);
      slot_result_type r;
      int              hit;
      r = no_slot(STAT_NOTFOUND, 0);
      case (cmd)
         CMD_LOOKUP, CMD_ACQUIRE, CMD_ADD: begin
            hit = -1;
            if (kind == KIND_FREE) begin
               r = no_slot(STAT_NOTFOUND, 0);
            end else begin
               // add only never looks for an existing entry
               if (cmd != CMD_ADD) hit = find_entry(kind, tag);
               if (hit >= 0) begin
                  if (cmd == CMD_ACQUIRE) bump_count(hit);
                  r = slot_view(STAT_FOUND, hit);
               end else if (cmd == CMD_LOOKUP) begin
                  r = no_slot(STAT_NOTFOUND, 0);
               end else begin
                  hit = claim_entry(kind, tag);
                  if (hit >= 0) begin
                     if (cmd == CMD_ACQUIRE) bump_count(hit);
                     r = slot_view(STAT_ADDED, hit);
                  end else if (cmd == CMD_ACQUIRE && fallback_on) begin
                     bump_count(0);
                     r = slot_view(STAT_FULL, 0);
                  end else begin
                     r = no_slot(STAT_FULL, 0);
                  end
               end
            end
         end
         CMD_RELEASE: begin
            if (int'(slot) >= NUM_SLOTS) begin
               r = no_slot(STAT_NOTFOUND, 0);
            end else begin
               if (cnt_tbl[slot] != '0) cnt_tbl[slot] = cnt_tbl[slot] - COUNT_W'(1);
               if (cnt_tbl[slot] == '0) begin
                  kind_tbl[slot] = KIND_FREE;
                  tag_tbl[slot]  = '0;
               end
               r = slot_view(STAT_DONE, int'(slot));
            end
         end
         CMD_REMOVE: begin
            hit = -1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (tag_tbl[i] == tag) begin
                  if (kind_tbl[i] != KIND_FREE && hit < 0) hit = i;
                  kind_tbl[i] = KIND_FREE;
                  tag_tbl[i]  = '0;
                  cnt_tbl[i]  = '0;
               end
            end
            r = (hit >= 0) ? no_slot(STAT_DONE, hit) : no_slot(STAT_NOTFOUND, 0);
         end
         CMD_CLEAR: begin
            wipe_table();
            r = no_slot(STAT_DONE, 0);
         end
         CMD_READ: begin
            if (int'(slot) >= NUM_SLOTS) r = no_slot(STAT_NOTFOUND, 0);
            else r = slot_view(STAT_DONE, int'(slot));
         end
         default: begin
            r = no_slot(STAT_NOTFOUND, 0);
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // monitor: CSR writes, result transactions, then command transactions
   always @(posedge clock) begin
      slot_result_type want;
      if (reset) begin
         wipe_table();
         fallback_on = 1'b1;
         pending_results.delete();
      end else begin
         if (psel && penable && pwrite && pready &&
             (paddr >> 2) == CSR_ADDR_W'(CSR_IDX_FALLBACK))
            fallback_on = pwdata[0];

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               n_errors++;
               $display("%0t: result transaction with none expected, %s %0h slot %0h",
                        $time, "actual status", rsp_mon.status,
                        rsp_mon.result_slot);
            end else begin
               want = pending_results.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_mon.status));
               check_field("result_slot", 16'(want.slot), 16'(rsp_mon.result_slot));
               check_field("slot_kind", 16'(want.kind), 16'(rsp_mon.slot_kind));
               check_field("slot_count", 16'(want.count), 16'(rsp_mon.slot_count));
               check_field("slot_tag", want.tag, rsp_mon.slot_tag);
            end
         end

         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(table_apply(req_mon.cmd, req_mon.entry_kind,
                                                  req_mon.tag, req_mon.slot));
      end
      n_waiting = pending_results.size();
   end

endmodule

FILE: tb/sv/refcounted_tag_slot_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_tag_slot_table_tb
// Stimulus and verdict for the slot table. A short directed sequence covers
// the corner cases, a saturation phase drives one count to its limit and
// fills the table, and random rounds with alternating fallback settings mix
// commands over a small key pool. Both handshake sides idle at random; the
// checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module refcounted_tag_slot_table_tb;
   import rcts_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   localparam int IDLE_MAX       = 19;
   localparam int STALL_CYCLES   = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int POOL_KEYS      = 24;
   localparam int POOL_TAGS      = 12;
   localparam int ROUNDS         = 4;
   localparam int ROUND_ITEMS    = 350;
   localparam int SAT_ACQUIRES   = 258;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   rcts_req_if req_if ();
   rcts_rsp_if rsp_if ();

   int chk_errors;
   int chk_waiting;
   int idle_run;
   bit send_gaps;
   bit recv_gaps;
   bit hold_rsp;

   logic [KIND_W-1:0] pool_kind [POOL_KEYS];
   logic [TAG_W-1:0]  pool_tag  [POOL_TAGS];

   always #2 clock = ~clock;

   refcounted_tag_slot_table u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   slot_table_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_if),
      .rsp_mon   (rsp_if),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .pready    (pready),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .n_errors  (chk_errors),
      .n_waiting (chk_waiting)
   );

   // watchdog: cycles without any transaction on any port
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable)) begin
         idle_run <= 0;
      end else if (idle_run >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   // result receiver: random stalls, occasional long hold-off
   initial begin
      int gap;
      int served;
      served = 0;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (served % 64 == 0) recv_gaps = ($urandom_range(0, 3) != 0);
         if (hold_rsp) begin
            gap      = STALL_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            gap = recv_gaps ? $urandom_range(0, IDLE_MAX) : 0;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         served++;
      end
   end

   // one command transaction, preceded by a random gap
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KIND_W-1:0] kind,
                           input logic [TAG_W-1:0] tag, input logic [SLOT_W-1:0] slot);
      int gap;
      gap = send_gaps ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= cmd;
      req_if.entry_kind <= kind;
      req_if.tag        <= tag;
      req_if.slot       <= slot;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // stop offering and wait until every result has come back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (chk_waiting != 0);
   endtask

   // APB write of the fallback register; only bit 0 is meaningful
   task automatic csr_write(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * CSR_IDX_FALLBACK);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // fresh key pool; tags are shared between kinds, with 0 and all-ones mixed in at random
   task automatic draw_pool();
      for (int i = 0; i < POOL_TAGS; i++) pool_tag[i] = TAG_W'($urandom);
      if ($urandom_range(0, 1)) pool_tag[0] = '0;
      if ($urandom_range(0, 1)) pool_tag[1] = '1;
      for (int i = 0; i < POOL_KEYS; i++) pool_kind[i] = KIND_W'($urandom_range(1, 7));
   endtask

   // lookup, acquire or add only, at random
   function automatic logic [CMD_W-1:0] CMD_WIDTH_PICK();
      case ($urandom_range(0, 2))
         0:       return CMD_LOOKUP;
         1:       return CMD_ACQUIRE;
         default: return CMD_ADD;
      endcase
   endfunction

   // one random command, mostly over the key pool
   task automatic random_cmd();
      int                pick;
      int                k;
      logic [KIND_W-1:0] rk;
      logic [TAG_W-1:0]  rt;
      logic [SLOT_W-1:0] rs;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, POOL_KEYS - 1);
      rk   = KIND_W'($urandom);
      rt   = TAG_W'($urandom);
      rs   = SLOT_W'($urandom);
      if (pick < 30)      send_cmd(CMD_ACQUIRE, pool_kind[k], pool_tag[k % POOL_TAGS], rs);
      else if (pick < 42) send_cmd(CMD_LOOKUP, pool_kind[k], pool_tag[k % POOL_TAGS], rs);
      else if (pick < 50) send_cmd(CMD_ADD, pool_kind[k], pool_tag[k % POOL_TAGS], rs);
      else if (pick < 70) send_cmd(CMD_RELEASE, rk, rt, rs);
      else if (pick < 77) send_cmd(CMD_REMOVE, rk, pool_tag[k % POOL_TAGS], rs);
      else if (pick < 87) send_cmd(CMD_READ, rk, rt, rs);
      else if (pick < 89) send_cmd(CMD_CLEAR, rk, rt, rs);
      else if (pick < 91) send_cmd(CMD_UNUSED, rk, rt, rs);
      else if (pick < 95) send_cmd(CMD_WIDTH_PICK(), KIND_FREE, pool_tag[k % POOL_TAGS], rs);
      else                send_cmd(CMD_W'($urandom), rk, rt, rs);
   endtask

   // main stimulus
   initial begin
      logic [KIND_W-1:0] sat_kind;
      logic [TAG_W-1:0]  sat_tag;
      req_if.valid      <= 1'b0;
      req_if.cmd        <= CMD_LOOKUP;
      req_if.entry_kind <= KIND_FREE;
      req_if.tag        <= '0;
      req_if.slot       <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      send_gaps          = 1'b1;
      hold_rsp           = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write({31'($urandom), 1'b1});

      // directed corner cases, starting from an empty table
      send_cmd(CMD_LOOKUP, 3'd7, 16'hFFFF, 4'd0);
      send_cmd(CMD_ACQUIRE, 3'd7, 16'hFFFF, 4'd0);
      send_cmd(CMD_ACQUIRE, 3'd7, 16'hFFFF, 4'd15);
      send_cmd(CMD_LOOKUP, 3'd7, 16'hFFFF, 4'd0);
      send_cmd(CMD_LOOKUP, 3'd1, 16'hFFFF, 4'd0);
      send_cmd(CMD_ADD, 3'd1, 16'h0000, 4'd0);
      send_cmd(CMD_ADD, 3'd1, 16'h0000, 4'd0);       // add only ignores the match
      send_cmd(CMD_ACQUIRE, 3'd1, 16'h0000, 4'd0);
      send_cmd(CMD_LOOKUP, KIND_FREE, 16'h0000, 4'd0); // free kind never matches
      send_cmd(CMD_ACQUIRE, KIND_FREE, 16'h0000, 4'd0);
      send_cmd(CMD_ADD, KIND_FREE, 16'hFFFF, 4'd0);
      send_cmd(CMD_RELEASE, 3'd0, 16'h0000, 4'd2);   // count already zero
      send_cmd(CMD_RELEASE, 3'd7, 16'hFFFF, 4'd2);   // slot already free
      send_cmd(CMD_READ, 3'd7, 16'hFFFF, 4'd15);
      send_cmd(CMD_READ, 3'd0, 16'h0000, 4'd0);
      send_cmd(CMD_RELEASE, 3'd0, 16'h0000, 4'd0);
      send_cmd(CMD_RELEASE, 3'd0, 16'h0000, 4'd0);
      send_cmd(CMD_ACQUIRE, 3'd3, 16'h1234, 4'd0);
      send_cmd(CMD_REMOVE, 3'd7, 16'h0000, 4'd0);
      send_cmd(CMD_REMOVE, 3'd7, 16'h0000, 4'd0);
      send_cmd(CMD_UNUSED, 3'd5, 16'hA5A5, 4'd9);
      send_cmd(CMD_ACQUIRE, 3'd7, 16'hFFFF, 4'd0);
      send_cmd(CMD_CLEAR, 3'd7, 16'hFFFF, 4'd15);
      send_cmd(CMD_READ, 3'd0, 16'h0000, 4'd0);
      wait_idle();

      // saturate slot 0, fill the table, then hit it while full
      sat_kind = KIND_W'($urandom_range(1, 7));
      sat_tag  = TAG_W'($urandom);
      send_cmd(CMD_CLEAR, 3'd0, 16'h0000, 4'd0);
      repeat (SAT_ACQUIRES) send_cmd(CMD_ACQUIRE, sat_kind, sat_tag, SLOT_W'($urandom));
      for (int i = 1; i < NUM_SLOTS_DEFAULT; i++)
         send_cmd(CMD_ACQUIRE, KIND_W'($urandom_range(1, 7)), sat_tag ^ TAG_W'(i), 4'd0);
      send_cmd(CMD_ACQUIRE, sat_kind, sat_tag ^ 16'h0100, 4'd0);  // fallback, count stuck
      send_cmd(CMD_ADD, sat_kind, sat_tag ^ 16'h0100, 4'd0);
      send_cmd(CMD_READ, 3'd0, 16'h0000, 4'd0);
      wait_idle();
      csr_write({31'($urandom), 1'b0});
      send_cmd(CMD_ACQUIRE, sat_kind, sat_tag ^ 16'h0100, 4'd0);  // full, no fallback
      send_cmd(CMD_ADD, sat_kind, sat_tag ^ 16'h0200, 4'd0);
      send_cmd(CMD_RELEASE, 3'd0, 16'h0000, 4'd0);
      wait_idle();

      // random rounds, fallback toggled between rounds
      for (int r = 0; r < ROUNDS; r++) begin
         csr_write({31'($urandom), ~r[0]});
         draw_pool();
         if (r == 1) hold_rsp = 1'b1;
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            if (n % 50 == 0) send_gaps = ($urandom_range(0, 3) != 0);
            random_cmd();
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (chk_errors == 0 && chk_waiting == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
